// File: hw/rtl/cpsm_pkg.sv
// Shared types for the Comba product-scanning multiplier.
// Transfer payloads and the per-operation control word; no dependencies.
package cpsm_pkg;

    // Width of every digit field on the ports
    localparam int FIELD_BITS = 32;

    // One operand digit pair
    typedef struct packed {
        logic [FIELD_BITS-1:0] a_digit;
        logic [FIELD_BITS-1:0] b_digit;
        logic                  last_pair;
    } operand_t;

    // One product digit
    typedef struct packed {
        logic [FIELD_BITS-1:0] product_digit;
        logic                  last_digit;
    } product_t;

    // Control word travelling with each issued digit-product operation
    typedef struct packed {
        logic term;     // a digit product is to be added
        logic col_end;  // final operation of a column: emit a digit
        logic last;     // final column of the product
    } op_t;

endpackage

// File: hw/rtl/comba_product_scanning_multiplier.sv
// Comba product-scanning multi-precision multiplier, top level.
// Depends on cpsm_pkg, cpsm_ram and cpsm_mac.
//
// Usage:
//   operand channel: one transfer per digit pair (a_digit, b_digit), least
//   significant first; last_pair marks the final pair and fixes the length n.
//   The MAX_DIGITS-th pair is taken as final whatever its flag.
//   product channel: 2n transfers, least significant digit first; last_digit
//   is set on the most significant one.
// Timing:
//   Loading takes one pair per cycle while operand_stall is low. After the
//   final pair the sequencer issues one digit-product read per cycle while
//   the product side does not stall, from the two operand RAMs (one read
//   port each), n*n reads plus one for the top column. After the final pair
//   the first product digit passes the RAM read, product and output registers.
//   operand_stall is high while the product is being issued; loading of the
//   next operand may start while earlier digits are still in the pipeline.
// Stall: a stalled product digit holds; the read, multiply and accumulate
//   stages freeze with it, so nothing is lost.
// Reset: clears sequencer, pipeline valids and accumulator; RAM contents are
//   left as they are, and only written digits are added into the product.
module comba_product_scanning_multiplier
    import cpsm_pkg::*;
#(
    parameter int MAX_DIGITS = 32,
    parameter int DIGIT_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     operand_valid,
    output logic     operand_stall,
    input  operand_t operand,
    output logic     product_valid,
    input  logic     product_stall,
    output product_t product
);

    localparam int AW = MAX_DIGITS > 1 ? $clog2(MAX_DIGITS) : 1;
    localparam int KW = $clog2(2 * MAX_DIGITS);
    localparam int SW = DIGIT_BITS < FIELD_BITS ? DIGIT_BITS : FIELD_BITS;

    typedef enum logic {ST_LOAD, ST_RUN} state_t;

    state_t          state_reg;
    logic [AW-1:0]   count_reg;
    logic [KW-1:0]   nm1_reg;
    logic [KW-1:0]   last_k_reg;
    logic [KW-1:0]   k_reg;
    logic [KW-1:0]   i_reg;

    logic            load;
    logic            load_last;
    logic            adv;
    logic            issue_valid;
    op_t             issue_op;
    logic [KW-1:0]   i_hi;
    logic [KW-1:0]   k_plus1;
    logic [KW-1:0]   i_lo_next;
    logic [KW-1:0]   b_idx;
    logic            last_col;
    logic            col_end;
    logic [SW-1:0]   a_data;
    logic [SW-1:0]   b_data;

    assign operand_stall = (state_reg == ST_RUN);
    assign load          = operand_valid && !operand_stall;
    assign load_last     = operand.last_pair || (count_reg == AW'(MAX_DIGITS - 1));

    // Column scan: row range for column k is max(0, k-n+1) .. min(k, n-1)
    assign last_col  = (k_reg == last_k_reg);
    assign i_hi      = (k_reg > nm1_reg) ? nm1_reg : k_reg;
    assign col_end   = last_col || (i_reg == i_hi);
    assign k_plus1   = k_reg + KW'(1);
    assign i_lo_next = (k_plus1 > nm1_reg) ? k_plus1 - nm1_reg : '0;
    assign b_idx     = k_reg - i_reg;

    assign issue_valid      = (state_reg == ST_RUN);
    assign issue_op.term    = !last_col;
    assign issue_op.col_end = col_end;
    assign issue_op.last    = last_col;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            nm1_reg    <= '0;
            last_k_reg <= '0;
            k_reg      <= '0;
            i_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (load)
                    begin
                        if (load_last)
                        begin
                            state_reg  <= ST_RUN;
                            count_reg  <= '0;
                            nm1_reg    <= KW'(count_reg);
                            last_k_reg <= KW'(count_reg) + KW'(count_reg) + KW'(1);
                            k_reg      <= '0;
                            i_reg      <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + AW'(1);
                        end
                    end
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        if (last_col)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else if (col_end)
                        begin
                            k_reg <= k_plus1;
                            i_reg <= i_lo_next;
                        end
                        else
                        begin
                            i_reg <= i_reg + KW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Operand stores
    cpsm_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_DIGITS)
    ) u_a_ram (
        .clk   (clk),
        .we    (load),
        .waddr (count_reg),
        .wdata (operand.a_digit[SW-1:0]),
        .re    (issue_valid && adv),
        .raddr (i_reg[AW-1:0]),
        .rdata (a_data)
    );

    cpsm_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_DIGITS)
    ) u_b_ram (
        .clk   (clk),
        .we    (load),
        .waddr (count_reg),
        .wdata (operand.b_digit[SW-1:0]),
        .re    (issue_valid && adv),
        .raddr (b_idx[AW-1:0]),
        .rdata (b_data)
    );

    // Multiply, accumulate and output slot
    cpsm_mac #(
        .DIGIT_BITS (DIGIT_BITS),
        .STORE_BITS (SW)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .issue_valid   (issue_valid),
        .issue_op      (issue_op),
        .a_data        (a_data),
        .b_data        (b_data),
        .adv           (adv),
        .product_valid (product_valid),
        .product_stall (product_stall),
        .product       (product)
    );

endmodule

// File: hw/rtl/cpsm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cpsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cpsm_mac.sv
// Multiply-accumulate datapath: digit product, three-digit accumulator, output register.
// Depends on cpsm_pkg; fed by the operand RAMs in the top level.
module cpsm_mac
    import cpsm_pkg::*;
#(
    parameter int DIGIT_BITS = 32,
    parameter int STORE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  issue_valid,
    input  op_t                   issue_op,
    input  logic [STORE_BITS-1:0] a_data,
    input  logic [STORE_BITS-1:0] b_data,
    output logic                  adv,
    output logic                  product_valid,
    input  logic                  product_stall,
    output product_t              product
);

    localparam int ACC_W = 3 * DIGIT_BITS;

    logic                    s1_valid_reg;
    op_t                     s1_op_reg;
    logic                    s2_valid_reg;
    op_t                     s2_op_reg;
    logic [2*STORE_BITS-1:0] prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        sum;
    logic                    out_valid_reg;
    product_t                out_reg;

    // Whole pipeline moves only when the output slot is free or being taken
    assign adv = !out_valid_reg || !product_stall;

    // Accumulator update
    assign sum = s2_op_reg.term ? acc_reg + ACC_W'(prod_reg) : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            if (s2_op_reg.last)
            begin
                acc_next = '0;
            end
            else if (s2_op_reg.col_end)
            begin
                acc_next = sum >> DIGIT_BITS;
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    // Control state of the stages and the output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_op_reg.col_end;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= issue_op;
            s2_op_reg <= s1_op_reg;
            prod_reg  <= a_data * b_data;
            if (s2_valid_reg && s2_op_reg.col_end)
            begin
                out_reg.product_digit <= FIELD_BITS'(sum[STORE_BITS-1:0]);
                out_reg.last_digit    <= s2_op_reg.last;
            end
        end
    end

    assign product_valid = out_valid_reg;
    assign product       = out_reg;

endmodule

// File: bench/comba_product_scanning_multiplier_tb.sv
// Self-checking testbench for the Comba product-scanning multiplier.
// Depends on cpsm_pkg and the comba_product_scanning_multiplier RTL; stands alone otherwise.
module comba_product_scanning_multiplier_tb;
    import cpsm_pkg::*;

    localparam int MAX_DIGITS    = 32;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 9;
    localparam int PAIRS_PER_RUN = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int N_DIRECTED    = 17;

    // Directed row: one digit pair, plus a product typed in by hand where obvious
    typedef struct packed {
        logic [FIELD_BITS-1:0]   a;
        logic [FIELD_BITS-1:0]   b;
        logic                    last;
        logic                    typed;
        logic [2*FIELD_BITS-1:0] product;
    } directed_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     operand_valid;
    logic     operand_stall;
    operand_t operand;
    logic     product_valid;
    logic     product_stall;
    product_t product;

    // Predictor state: operand digits held for the product being loaded
    logic [FIELD_BITS-1:0] a_digits [MAX_DIGITS];
    logic [FIELD_BITS-1:0] b_digits [MAX_DIGITS];
    int                    pairs_loaded = 0;
    product_t              new_digits [$];
    product_t              awaited_digits [$];

    directed_row_t directed_rows [N_DIRECTED];

    int sender_idle_pct   = 23;
    int receiver_idle_pct = 66;
    int pairs_sent        = 0;
    int products_formed   = 0;
    int digits_checked    = 0;
    int mismatch_count    = 0;
    int longest_operand   = 0;
    int cycle_count       = 0;

    comba_product_scanning_multiplier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand       (operand),
        .product_valid (product_valid),
        .product_stall (product_stall),
        .product       (product)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Store one pair; on the final pair (or the saturating one) form all 2n product digits
    function automatic void form_product(input operand_t p);
        int          idx;
        int          n;
        logic [95:0] column_acc;
        product_t    d;
        new_digits.delete();
        idx = (pairs_loaded >= MAX_DIGITS) ? MAX_DIGITS - 1 : pairs_loaded;
        a_digits[idx] = p.a_digit;
        b_digits[idx] = p.b_digit;
        n = idx + 1;
        if (!p.last_pair && n < MAX_DIGITS)
        begin
            pairs_loaded = n;
            return;
        end
        if (n > longest_operand)
            longest_operand = n;
        column_acc = '0;
        for (int k = 0; k < 2 * n; k++)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (k >= i && k - i < n)
                    column_acc = column_acc + 96'(a_digits[i]) * 96'(b_digits[k - i]);
            end
            d.product_digit = column_acc[FIELD_BITS-1:0];
            d.last_digit    = (k == 2 * n - 1);
            new_digits.push_back(d);
            column_acc = column_acc >> FIELD_BITS;
        end
        pairs_loaded = 0;
    endfunction

    // Half corner values, half uniform
    function automatic logic [FIELD_BITS-1:0] random_digit();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(FIELD_BITS - 1);
            3: return ~(32'h1 << $urandom_range(FIELD_BITS - 1));
            default: return $urandom();
        endcase
    endfunction

    // Short operands dominate; a few long ones
    function automatic int random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return $urandom_range(4, 1);
        else if (pick < 90)
            return $urandom_range(10, 5);
        else
            return $urandom_range(MAX_DIGITS, 11);
    endfunction

    // One operand transfer, with random idle cycles ahead of it
    task automatic send_pair(input operand_t p, input logic typed,
                             input logic [2*FIELD_BITS-1:0] known);
        product_t d;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            operand_valid <= 1'b0;
            @(posedge clk);
        end
        operand       <= p;
        operand_valid <= 1'b1;
        do
            @(posedge clk);
        while (operand_stall);
        form_product(p);
        // hand-typed product replaces the predicted one
        if (typed)
        begin
            new_digits.delete();
            d.product_digit = known[FIELD_BITS-1:0];
            d.last_digit    = 1'b0;
            new_digits.push_back(d);
            d.product_digit = known[2*FIELD_BITS-1:FIELD_BITS];
            d.last_digit    = 1'b1;
            new_digits.push_back(d);
        end
        if (new_digits.size() != 0)
            products_formed++;
        foreach (new_digits[j])
            awaited_digits.push_back(new_digits[j]);
        pairs_sent++;
    endtask

    // Whole operand of random digits; a saturating load never raises last_pair
    task automatic send_random_operand(input int n_pairs, input bit saturate);
        operand_t p;
        for (int i = 0; i < n_pairs; i++)
        begin
            p.a_digit   = random_digit();
            p.b_digit   = random_digit();
            p.last_pair = saturate ? 1'b0 : (i == n_pairs - 1);
            send_pair(p, 1'b0, '0);
        end
    endtask

    // Hold the operand side off until every product digit has come back
    task automatic wait_for_products();
        operand_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_digits.size() != 0);
    endtask

    // Product side: random stall, check each transfer against the oldest expectation
    always @(posedge clk)
    begin : product_check
        product_t want;
        if (rst_n)
        begin
            if (product_valid && !product_stall)
            begin
                if (awaited_digits.size() == 0)
                begin
                    $error("unexpected product digit %h (last_digit %b)",
                           product.product_digit, product.last_digit);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_digits.pop_front();
                    if (product.product_digit !== want.product_digit)
                    begin
                        $error("product_digit: expected %h, got %h",
                               want.product_digit, product.product_digit);
                        mismatch_count++;
                    end
                    if (product.last_digit !== want.last_digit)
                    begin
                        $error("last_digit: expected %b, got %b",
                               want.last_digit, product.last_digit);
                        mismatch_count++;
                    end
                    digits_checked++;
                end
            end
            product_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
        else
        begin
            product_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d product digits outstanding",
                     cycle_count, awaited_digits.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        directed_row_t row;
        int            run_start;

        rst_n         = 1'b0;
        operand_valid = 1'b0;
        operand       = '0;

        // a, b, last_pair, typed, product
        directed_rows = '{
            {32'h00000000, 32'h00000000, 1'b1, 1'b1, 64'h00000000_00000000},
            {32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 64'hFFFFFFFE_00000001},
            {32'hFFFFFFFF, 32'h00000001, 1'b1, 1'b1, 64'h00000000_FFFFFFFF},
            {32'h00000001, 32'hFFFFFFFF, 1'b1, 1'b1, 64'h00000000_FFFFFFFF},
            {32'h80000000, 32'h00000002, 1'b1, 1'b1, 64'h00000001_00000000},
            {32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 64'h0},
            {32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 64'h0},
            {32'hDEADBEEF, 32'h00000000, 1'b0, 1'b0, 64'h0},
            {32'h00000000, 32'h12345678, 1'b0, 1'b0, 64'h0},
            {32'hFFFFFFFF, 32'h80000000, 1'b1, 1'b0, 64'h0},
            {32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0, 64'h0},
            {32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b0, 64'h0},
            {32'hAAAAAAAA, 32'h55555555, 1'b0, 1'b0, 64'h0},
            {32'h55555555, 32'hAAAAAAAA, 1'b0, 1'b0, 64'h0},
            {32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 64'h0},
            {32'h00000001, 32'hFFFFFFFF, 1'b1, 1'b0, 64'h0},
            {32'h00000007, 32'h00000009, 1'b1, 1'b1, 64'h00000000_0000003F}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            row = directed_rows[r];
            send_pair({row.a, row.b, row.last}, row.typed, row.product);
        end
        wait_for_products();

        // random operands under three idling plans, drained between them
        for (int plan = 0; plan < 3; plan++)
        begin
            case (plan)
                0: begin sender_idle_pct = 23; receiver_idle_pct = 66; end
                1: begin sender_idle_pct = 66; receiver_idle_pct = 23; end
                default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase
            run_start = pairs_sent;
            // a full-length load with last_pair never set must still end the operand
            if (plan == 0)
                send_random_operand(MAX_DIGITS, 1'b1);
            while (pairs_sent - run_start < PAIRS_PER_RUN)
                send_random_operand(random_length(), 1'b0);
            wait_for_products();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d digit pairs loaded into %0d products (operands up to %0d digits)",
                 pairs_sent, products_formed, longest_operand);
        $display("%0d product digits checked under mixed idling; %0d mismatches",
                 digits_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
